// ===== src/toc_pkg.sv =====
// Shared types and constants of the timed output channel controller.
`default_nettype none

package toc_pkg;

    localparam int MaxChannels = 8;
    localparam int ChIdxW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

    localparam int ActW  = 4;
    localparam int CmdW  = 2;
    localparam int ChanW = 3;
    localparam int DurW  = 16;
    localparam int TimeW = 32;
    localparam int MapW  = 8;

    localparam logic [ActW-1:0] ActMax = ActW'(MaxChannels);

    // 1000 = 1024 - 16 - 8, so seconds become milliseconds in three adder steps.
    localparam int MulShA = 10;
    localparam int MulShB = 4;
    localparam int MulShC = 3;

    typedef enum logic [CmdW-1:0] {
        CMD_SET     = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_ALL_OFF = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SET_ADD,
        S_SET_SUB_A,
        S_SET_SUB_B,
        S_TICK,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [MaxChannels-1:0] clr_mask;
        logic                   wr_en;
        logic [ChIdxW-1:0]      wr_idx;
        logic [TimeW-1:0]       wr_deadline;
    } t_store_ctl;

    typedef struct packed {
        logic [TimeW-1:0] a;
        logic [TimeW-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

`default_nettype wire

// ===== src/toc_alu.sv =====
// Shared 32-bit adder and subtractor used by every arithmetic step.
`default_nettype none

module toc_alu import toc_pkg::*; (
    input  t_alu_req         i_req,
    output logic [TimeW-1:0] o_y
);

    assign o_y = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);

endmodule

`default_nettype wire

// ===== src/toc_chan_store.sv =====
// Per-channel on bits and off deadlines.
`default_nettype none

module toc_chan_store import toc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_store_ctl             i_ctl,
    input  logic [ChIdxW-1:0]      i_rd_idx,
    output logic [TimeW-1:0]       o_rd_deadline,
    output logic [MaxChannels-1:0] o_on_bits
);

    logic [MaxChannels-1:0] r_on;
    logic [MaxChannels-1:0] n_on;
    logic [TimeW-1:0]       r_deadline [MaxChannels];

    // A deadline is only looked at while its channel is on, so it needs no reset.
    always_comb begin
        n_on = r_on & ~i_ctl.clr_mask;
        if (i_ctl.wr_en) begin
            n_on[i_ctl.wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on <= '0;
        end else begin
            r_on <= n_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_deadline[i_ctl.wr_idx] <= i_ctl.wr_deadline;
        end
    end

    assign o_rd_deadline = r_deadline[i_rd_idx];
    assign o_on_bits     = r_on;

endmodule

`default_nettype wire

// ===== src/timed_output_channel_controller_core.sv =====
// Top level of the timed output channel controller: sequencer and result register.
//
// Channels: the input channel (i_in_valid / o_in_ready) carries one command item,
// the output channel (o_out_valid / i_out_ready) returns one result item per
// command, and the configuration channel (i_cfg_valid / o_cfg_ready) writes the
// active channel count. Configuration is taken only while the sequencer is idle.
// Off, all-off, latched on, invalid index and unused codes go from acceptance
// straight to the result state. A timed on first passes the add and two subtract
// states, as its deadline is built by three passes through the one shared 32-bit
// adder; a tick walks the channel slots one per cycle through that same adder
// to form the wrap-safe difference. The sequencer takes one item at a time, with
// o_in_ready high only while idle, and returns to idle as it loads a result.
// After reset all channels are off, the count is MaxChannels and no result is
// pending. A result waits in the output register while the receiver stalls;
// the next item is still accepted and worked on, and the sequencer then holds in
// its result state, with o_in_ready low, until the output register is free.
`default_nettype none

module timed_output_channel_controller_core import toc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,

    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CmdW-1:0]  i_cmd,
    input  logic [ChanW-1:0] i_channel,
    input  logic             i_turn_on,
    input  logic [DurW-1:0]  i_duration_s,
    input  logic [TimeW-1:0] i_now_ms,

    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_status,
    output logic [MapW-1:0]  o_channel_states,

    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [ActW-1:0]  i_active_channels
);

    t_state                 r_state;
    t_state                 n_state;
    logic [TimeW-1:0]       r_now;
    logic [DurW-1:0]        r_dur;
    logic [ChIdxW-1:0]      r_ch;
    logic [TimeW-1:0]       r_acc;
    logic [ChIdxW-1:0]      r_idx;
    logic                   r_status;
    logic [ActW-1:0]        r_active;
    logic                   r_out_valid;
    logic                   r_out_status;
    logic [MapW-1:0]        r_out_map;

    t_store_ctl             w_ctl;
    t_alu_req               w_alu;
    logic [TimeW-1:0]       w_alu_y;
    logic [TimeW-1:0]       w_rd_deadline;
    logic [MaxChannels-1:0] w_on_bits;
    logic [MaxChannels-1:0] w_active_mask;
    logic [MaxChannels-1:0] w_cfg_mask;
    logic [ActW-1:0]        w_cfg_n;
    logic [ActW-1:0]        w_cfg_lo;
    logic [ActW-1:0]        w_cfg_hi;
    logic                   w_in_acc;
    logic                   w_cfg_acc;
    logic                   w_ch_ok;
    logic                   w_expire;
    logic                   w_out_free;
    logic                   w_load_out;

    toc_alu u_alu (
        .i_req (w_alu),
        .o_y   (w_alu_y)
    );

    toc_chan_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_rd_idx      (r_idx),
        .o_rd_deadline (w_rd_deadline),
        .o_on_bits     (w_on_bits)
    );

    // Handshakes. Configuration wins the idle cycle over a command item.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_out  = (r_state == S_RESULT) && w_out_free;

    // A channel index is usable only below the active count, which never
    // exceeds MaxChannels.
    assign w_ch_ok = ActW'(i_channel) < r_active;

    // Count write: saturate, then clear every slot between old and new counts.
    assign w_cfg_n  = (i_active_channels > ActMax) ? ActMax : i_active_channels;
    assign w_cfg_lo = (w_cfg_n < r_active) ? w_cfg_n : r_active;
    assign w_cfg_hi = (w_cfg_n < r_active) ? r_active : w_cfg_n;

    always_comb begin
        for (int i = 0; i < MaxChannels; i++) begin
            w_active_mask[i] = ActW'(i) < r_active;
            w_cfg_mask[i]    = (ActW'(i) >= w_cfg_lo) && (ActW'(i) < w_cfg_hi);
        end
    end

    // A tick turns a slot off when it is on, timed and below the active count, and
    // now - deadline is not negative as a signed 32-bit value.
    assign w_expire = w_on_bits[r_idx] && (w_rd_deadline != '0) && !w_alu_y[TimeW-1]
                      && (ActW'(r_idx) < r_active);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if ((i_cmd == CMD_SET) && w_ch_ok && i_turn_on && (i_duration_s != '0)) begin
                        n_state = S_SET_ADD;
                    end else if (i_cmd == CMD_TICK) begin
                        n_state = S_TICK;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SET_ADD:   n_state = S_SET_SUB_A;
            S_SET_SUB_A: n_state = S_SET_SUB_B;
            S_SET_SUB_B: n_state = S_RESULT;
            S_TICK: begin
                if (r_idx == ChIdxW'(MaxChannels - 1)) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control: adder operands and channel store updates.
    always_comb begin
        w_ctl.clr_mask    = '0;
        w_ctl.wr_en       = 1'b0;
        w_ctl.wr_idx      = r_ch;
        w_ctl.wr_deadline = '0;
        w_alu.a           = r_now;
        w_alu.b           = TimeW'(r_dur) << MulShA;
        w_alu.sub         = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_cfg_acc) begin
                    w_ctl.clr_mask = w_cfg_mask;
                end
                if (w_in_acc) begin
                    w_ctl.wr_idx = i_channel[ChIdxW-1:0];
                    if ((i_cmd == CMD_SET) && w_ch_ok) begin
                        if (!i_turn_on) begin
                            w_ctl.clr_mask = MaxChannels'(1) << i_channel;
                        end else if (i_duration_s == '0) begin
                            // Latched on: no expiry.
                            w_ctl.wr_en = 1'b1;
                        end
                    end else if (i_cmd == CMD_ALL_OFF) begin
                        w_ctl.clr_mask = w_active_mask;
                    end
                end
            end
            S_SET_ADD: begin
                w_alu.a = r_now;
                w_alu.b = TimeW'(r_dur) << MulShA;
            end
            S_SET_SUB_A: begin
                w_alu.a   = r_acc;
                w_alu.b   = TimeW'(r_dur) << MulShB;
                w_alu.sub = 1'b1;
            end
            S_SET_SUB_B: begin
                w_alu.a     = r_acc;
                w_alu.b     = TimeW'(r_dur) << MulShC;
                w_alu.sub   = 1'b1;
                w_ctl.wr_en = 1'b1;
                // A timed deadline that lands on zero would read as latched.
                w_ctl.wr_deadline = (w_alu_y == '0) ? TimeW'(1) : w_alu_y;
            end
            S_TICK: begin
                w_alu.a   = r_now;
                w_alu.b   = w_rd_deadline;
                w_alu.sub = 1'b1;
                if (w_expire) begin
                    w_ctl.clr_mask = MaxChannels'(1) << r_idx;
                end
            end
            S_RESULT: begin
                w_ctl.clr_mask = '0;
            end
            default: begin
                w_ctl.clr_mask = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= ActMax;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                r_active <= w_cfg_n;
            end
            if (w_in_acc) begin
                r_idx <= '0;
            end else if (r_state == S_TICK) begin
                r_idx <= r_idx + ChIdxW'(1);
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now    <= i_now_ms;
            r_dur    <= i_duration_s;
            r_ch     <= i_channel[ChIdxW-1:0];
            r_status <= (i_cmd == CMD_SET) && !w_ch_ok;
        end
        if ((r_state == S_SET_ADD) || (r_state == S_SET_SUB_A)) begin
            r_acc <= w_alu_y;
        end
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_map    <= MapW'(w_on_bits & w_active_mask);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_channel_states = r_out_map;

    // No slot at or above the active count is ever on.
    a_no_stale_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_on_bits & ~w_active_mask) == '0)
        else $error("channel on above the active count");

    // A set with an invalid index leaves every channel as it was.
    a_invalid_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_cmd == CMD_SET) && !w_ch_ok) |=> $stable(w_on_bits))
        else $error("invalid set command changed channel state");

    // All-off leaves no active channel on.
    a_all_off_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_cmd == CMD_ALL_OFF)) |=> ((w_on_bits & w_active_mask) == '0))
        else $error("all-off left a channel on");

    // A pending result stays valid and unchanged until the receiver takes it.
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_map)))
        else $error("pending result lost or overwritten");

endmodule

`default_nettype wire

// ===== tb/timed_output_channel_controller_core_tb.sv =====
// Testbench of the timed output channel controller: directed and random commands checked against a predictor.
`default_nettype none

module timed_output_channel_controller_core_tb;
    import toc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HalfPeriod = 10;
    localparam int CycleLimit = 200000;
    localparam int SettleCycles = 16;
    localparam int ReportMax = 10;

    // The command code that the block leaves unused, and the two status codes.
    localparam logic [CmdW-1:0] CmdUnused = 2'd3;
    localparam logic StatusOk = 1'b0;
    localparam logic StatusBadChannel = 1'b1;
    localparam logic [TimeW-1:0] MsPerSec = 32'd1000;

    typedef struct {
        logic [CmdW-1:0]  cmd;
        logic [ChanW-1:0] channel;
        logic             turn_on;
        logic [DurW-1:0]  duration_s;
        logic [TimeW-1:0] now_ms;
        bit               wait_idle;
    } t_cmd_item;

    typedef struct {
        logic            status;
        logic [MapW-1:0] states;
    } t_channel_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [CmdW-1:0]  i_cmd = '0;
    logic [ChanW-1:0] i_channel = '0;
    logic             i_turn_on = 1'b0;
    logic [DurW-1:0]  i_duration_s = '0;
    logic [TimeW-1:0] i_now_ms = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_status;
    logic [MapW-1:0]  o_channel_states;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [ActW-1:0]  i_active_channels = '0;

    timed_output_channel_controller_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_channel         (i_channel),
        .i_turn_on         (i_turn_on),
        .i_duration_s      (i_duration_s),
        .i_now_ms          (i_now_ms),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_channel_states  (o_channel_states),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_active_channels (i_active_channels)
    );

    always begin
        #HalfPeriod i_clk = 1'b1;
        #HalfPeriod i_clk = 1'b0;
    end

    // Commands waiting to be sent, and the results that accepted commands still owe.
    t_cmd_item       cmd_queue[$];
    t_channel_result owed_results[$];
    t_cmd_item       shown_item;
    bit              item_shown = 1'b0;

    int mismatches = 0;
    int cycles = 0;

    // Predicted channel state and active count.
    logic [MaxChannels-1:0] ch_on_model = '0;
    logic [TimeW-1:0]       deadline_model [MaxChannels];
    int                     count_model = MaxChannels;

    // Millisecond time that the well-formed random commands follow.
    logic [TimeW-1:0] ms_clock = '0;

    function automatic logic [MapW-1:0] on_map();
        logic [MapW-1:0] m;
        m = '0;
        for (int i = 0; i < count_model; i++) begin
            if (ch_on_model[i]) begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    task automatic clear_channel(input int i);
        ch_on_model[i] = 1'b0;
        deadline_model[i] = '0;
    endtask

    // Applies one command to the predicted state and gives the result it owes.
    task automatic run_command(input t_cmd_item it, output t_channel_result res);
        logic [TimeW-1:0] dl;
        logic [TimeW-1:0] diff;
        res.status = StatusOk;
        case (it.cmd)
            CMD_SET: begin
                if (int'(it.channel) >= count_model) begin
                    res.status = StatusBadChannel;
                end else if (it.turn_on) begin
                    dl = '0;
                    if (it.duration_s != '0) begin
                        dl = it.now_ms + TimeW'(it.duration_s) * MsPerSec;
                        // A timed deadline that lands on zero would read as latched.
                        if (dl == '0) begin
                            dl = 32'd1;
                        end
                    end
                    ch_on_model[it.channel] = 1'b1;
                    deadline_model[it.channel] = dl;
                end else begin
                    clear_channel(it.channel);
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < count_model; i++) begin
                    diff = it.now_ms - deadline_model[i];
                    if (ch_on_model[i] && deadline_model[i] != '0 && !diff[TimeW-1]) begin
                        clear_channel(i);
                    end
                end
            end
            CMD_ALL_OFF: begin
                for (int i = 0; i < count_model; i++) begin
                    clear_channel(i);
                end
            end
            default: begin
            end
        endcase
        res.states = on_map();
    endtask

    // A count write clears the channels between the old and the new count.
    task automatic apply_count(input logic [ActW-1:0] v);
        int n;
        int lo;
        int hi;
        n = (int'(v) > MaxChannels) ? MaxChannels : int'(v);
        lo = (n < count_model) ? n : count_model;
        hi = (n < count_model) ? count_model : n;
        for (int i = lo; i < hi; i++) begin
            clear_channel(i);
        end
        count_model = n;
    endtask

    function automatic t_cmd_item mk(input logic [CmdW-1:0] c, input int ch, input bit on,
                                     input logic [DurW-1:0] dur, input logic [TimeW-1:0] now);
        t_cmd_item it;
        it.cmd = c;
        it.channel = ChanW'(ch);
        it.turn_on = on;
        it.duration_s = dur;
        it.now_ms = now;
        it.wait_idle = 1'b0;
        return it;
    endfunction

    // Mostly commands that follow a running clock, so that timed channels really expire;
    // the rest is noise with every field random.
    function automatic t_cmd_item random_cmd();
        t_cmd_item it;
        int pick;
        it = mk(CMD_SET, 0, 1'b0, '0, '0);
        if ($urandom_range(0, 99) < 8) begin
            it.cmd = CmdW'($urandom_range(0, 3));
            it.channel = ChanW'($urandom);
            it.turn_on = 1'($urandom);
            it.duration_s = DurW'($urandom);
            it.now_ms = $urandom;
            return it;
        end
        it.channel = ChanW'($urandom);
        it.duration_s = DurW'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            it.cmd = CMD_SET;
            if (count_model > 0 && $urandom_range(0, 99) < 85) begin
                it.channel = ChanW'($urandom_range(0, count_model - 1));
            end
            it.turn_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                it.duration_s = DurW'($urandom_range(1, 4));
            end else if (pick < 75) begin
                it.duration_s = '0;
            end else if (pick < 85) begin
                it.duration_s = '1;
            end
            it.now_ms = ms_clock + $urandom_range(0, 200);
        end else if (pick < 85) begin
            it.cmd = CMD_TICK;
            ms_clock = ms_clock + $urandom_range(0, 1500);
            it.now_ms = ms_clock;
        end else if (pick < 93) begin
            it.cmd = CMD_ALL_OFF;
            it.now_ms = $urandom;
        end else begin
            it.cmd = CmdUnused;
            it.now_ms = $urandom;
        end
        return it;
    endfunction

    // Sender: bursts of items with gaps between them, fed from the command queue.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin : driver
        t_channel_result res;
        bit free;
        if (i_rst_n) begin
            free = !i_in_valid;
            if (i_in_valid && o_in_ready) begin
                run_command(shown_item, res);
                owed_results.push_back(res);
                item_shown = 1'b0;
                free = 1'b1;
            end
            if (free) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (cmd_queue.size() != 0 &&
                             !(cmd_queue[0].wait_idle && owed_results.size() != 0)) begin
                    shown_item = cmd_queue.pop_front();
                    item_shown = 1'b1;
                    i_in_valid <= 1'b1;
                    i_cmd <= shown_item.cmd;
                    i_channel <= shown_item.channel;
                    i_turn_on <= shown_item.turn_on;
                    i_duration_s <= shown_item.duration_s;
                    i_now_ms <= shown_item.now_ms;
                    burst_left--;
                    if (burst_left <= 0) begin
                        if ($urandom_range(0, 9) == 0) begin
                            burst_left = $urandom_range(40, 80);
                            gap_left = 0;
                        end else begin
                            burst_left = $urandom_range(1, 20);
                            gap_left = $urandom_range(0, 8);
                        end
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result and stalls on a pattern that changes mode now and then.
    int          stall_mode = 0;
    int          mode_timer = 0;
    logic [15:0] stall_pat = 16'hFFFF;

    always @(posedge i_clk) begin : monitor
        t_channel_result want;
        logic rdy;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportMax) begin
                    $display("unexpected result: status %0d states %02h",
                             o_status, o_channel_states);
                end
            end else begin
                want = owed_results.pop_front();
                if (o_status !== want.status || o_channel_states !== want.states) begin
                    mismatches++;
                    if (mismatches <= ReportMax) begin
                        $display("result mismatch: expected status %0d states %02h, got %0d %02h",
                                 want.status, want.states, o_status, o_channel_states);
                    end
                end
            end
        end
        mode_timer++;
        if (mode_timer >= 50) begin
            mode_timer = 0;
            stall_mode = $urandom_range(0, 3);
            stall_pat = 16'($urandom);
        end
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = 1'($urandom);
            2: begin
                rdy = stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[15:1]};
            end
            default: rdy = ($urandom_range(0, 3) == 0);
        endcase
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send(input t_cmd_item it);
        cmd_queue.push_back(it);
    endtask

    // Waits until every queued item went out and every owed result came back,
    // then lets the sequencer settle before anything else happens.
    task automatic drain();
        while (cmd_queue.size() != 0 || item_shown || owed_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [ActW-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_active_channels <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        apply_count(v);
        i_cfg_valid <= 1'b0;
    endtask

    logic [ActW-1:0] phase_counts [8] = '{4'd8, 4'd4, 4'd15, 4'd1, 4'd6, 4'd0, 4'd11, 4'd8};
    int              phase_items  [8] = '{100, 80, 80, 60, 80, 20, 70, 60};

    initial begin
        t_cmd_item it;
        for (int i = 0; i < MaxChannels; i++) begin
            deadline_model[i] = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset count of eight channels.
        send(mk(CMD_SET, 0, 1'b1, 16'd0, 32'd0));              // latched on
        send(mk(CMD_SET, 7, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));   // longest duration, wraps
        send(mk(CMD_SET, 3, 1'b1, 16'd1, 32'hFFFF_FC18));      // deadline lands on zero
        send(mk(CMD_TICK, 0, 1'b0, 16'd0, 32'd0));             // one short of the deadline
        send(mk(CMD_TICK, 0, 1'b0, 16'd0, 32'd1));             // exactly at the deadline
        send(mk(CMD_SET, 3, 1'b1, 16'd2, 32'd1000));
        send(mk(CMD_SET, 3, 1'b1, 16'd5, 32'd1000));           // already on: renew only
        send(mk(CMD_TICK, 0, 1'b0, 16'd0, 32'd3000));
        send(mk(CMD_TICK, 0, 1'b0, 16'd0, 32'd6000));
        send(mk(CMD_SET, 0, 1'b0, 16'hFFFF, 32'd0));           // off
        send(mk(CMD_SET, 5, 1'b0, 16'd0, 32'd0));              // off while already off
        send(mk(CmdUnused, 7, 1'b1, 16'hFFFF, 32'hFFFF_FFFF));
        // Half the counter range past the deadline reads as already expired.
        send(mk(CMD_SET, 1, 1'b1, 16'd1, 32'h7FFF_FFFF));
        send(mk(CMD_TICK, 0, 1'b0, 16'd0, 32'd0));
        send(mk(CMD_SET, 2, 1'b1, 16'd3, 32'd0));
        send(mk(CMD_ALL_OFF, 0, 1'b0, 16'd0, 32'd0));
        drain();

        // A smaller count turns indexes at and above it invalid.
        write_count(4'd3);
        send(mk(CMD_SET, 2, 1'b1, 16'd0, 32'd0));
        send(mk(CMD_SET, 3, 1'b1, 16'd0, 32'd0));
        send(mk(CMD_SET, 7, 1'b0, 16'd0, 32'd0));
        drain();
        write_count(4'd0);
        send(mk(CMD_SET, 0, 1'b1, 16'd0, 32'd0));
        send(mk(CMD_TICK, 0, 1'b0, 16'd0, 32'hFFFF_FFFF));
        drain();
        // A count above the maximum saturates.
        write_count(4'd15);
        send(mk(CMD_SET, 7, 1'b1, 16'd0, 32'd0));
        drain();

        // Random phases, each at its own count; one runs across the wrap of the time.
        for (int p = 0; p < 8; p++) begin
            write_count(phase_counts[p]);
            ms_clock = (p == 2) ? 32'hFFFF_0000 : $urandom;
            for (int k = 0; k < phase_items[p]; k++) begin
                it = random_cmd();
                // Once a phase the sender holds off until every result is back.
                it.wait_idle = (k == phase_items[p] / 2);
                send(it);
            end
            drain();
        end

        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
